// ===== sv/saf_pkg.sv =====
// ----------------------------------------------------------------------------
// saf_pkg
// Shared types and constants for the sparse affine form add/sub unit.
// ----------------------------------------------------------------------------
`default_nettype none

package saf_pkg;

    // Default sizing
    localparam int SAF_MAX_TERMS  = 16;
    localparam int SAF_INDEX_BITS = 16;

    // Fixed field widths of the channels
    localparam int REQ_W   = 3;
    localparam int NIDX_W  = 16;
    localparam int VALUE_W = 64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TERM_A   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TERM_B   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CENTER_A = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CENTER_B = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COMBINE  = 3'd4;

    // Saturation limits, signed Q31.32
    localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Input item
    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [NIDX_W-1:0]         noise_index;
        logic signed [VALUE_W-1:0] value;
        logic                      subtract;
    } t_in;

    // Result item
    typedef struct packed {
        logic                      is_term;
        logic [NIDX_W-1:0]         noise_index_res;
        logic signed [VALUE_W-1:0] value_res;
        logic                      overflow;
        logic                      last;
    } t_out;

endpackage

`default_nettype wire

// ===== sv/saf_term_store.sv =====
// ----------------------------------------------------------------------------
// saf_term_store
// Term memory of one form: index and coefficient per entry, one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module saf_term_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int IDX_W  = 16
) (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire [ADDR_W-1:0]             i_wr_addr,
    input  wire [IDX_W-1:0]              i_wr_idx,
    input  wire [saf_pkg::VALUE_W-1:0]   i_wr_coef,
    input  wire [ADDR_W-1:0]             i_rd_addr,
    output logic [IDX_W-1:0]             o_rd_idx,
    output logic [saf_pkg::VALUE_W-1:0]  o_rd_coef
);
    import saf_pkg::*;

    logic [IDX_W+VALUE_W-1:0] mem [DEPTH];
    logic [IDX_W+VALUE_W-1:0] r_rd;

    // Append a term
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_idx, i_wr_coef};
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_idx  = r_rd[IDX_W+VALUE_W-1:VALUE_W];
    assign o_rd_coef = r_rd[VALUE_W-1:0];

endmodule

`default_nettype wire

// ===== sv/saf_sat_alu.sv =====
// ----------------------------------------------------------------------------
// saf_sat_alu
// Saturating signed 64-bit add/subtract shared by center and term merges.
// ----------------------------------------------------------------------------
`default_nettype none

module saf_sat_alu (
    input  wire [saf_pkg::VALUE_W-1:0]  i_a,
    input  wire [saf_pkg::VALUE_W-1:0]  i_b,
    input  wire                         i_sub,
    output logic [saf_pkg::VALUE_W-1:0] o_res,
    output logic                        o_ov
);
    import saf_pkg::*;

    logic [VALUE_W-1:0] raw;

    // Wrap-around result, then detect sign overflow and clamp
    always_comb begin
        raw = i_sub ? (i_a - i_b) : (i_a + i_b);
        if (i_sub) begin
            o_ov = (i_a[VALUE_W-1] != i_b[VALUE_W-1]) && (raw[VALUE_W-1] != i_a[VALUE_W-1]);
        end else begin
            o_ov = (i_a[VALUE_W-1] == i_b[VALUE_W-1]) && (raw[VALUE_W-1] != i_a[VALUE_W-1]);
        end
        o_res = o_ov ? (i_a[VALUE_W-1] ? VAL_MIN : VAL_MAX) : raw;
    end

endmodule

`default_nettype wire

// ===== sv/sparse_affine_form_add_sub_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_affine_form_add_sub_unit
// Loads two sparse affine forms into term memories and merges them on combine.
// ----------------------------------------------------------------------------
// Load items produce no result.
// A combine moves to the center state, which registers the center item once
// the output register is free; the first merged term is registered by the merge
// step after the center, and each later term by a memory read state, then a
// merge step, with every result load waiting while the output register is full.
// Synchronous active-low reset clears counts, centers, flags and control;
// term memories are not cleared, only entries below the counts are used.
`default_nettype none

module sparse_affine_form_add_sub_unit #(
    parameter int MAX_TERMS  = saf_pkg::SAF_MAX_TERMS,
    parameter int INDEX_BITS = saf_pkg::SAF_INDEX_BITS
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  saf_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output saf_pkg::t_out  o_out
);
    import saf_pkg::*;

    localparam int IDX_W  = (INDEX_BITS < NIDX_W) ? INDEX_BITS : NIDX_W;
    localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CENT = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_MRG  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]   r_i, n_i, r_j, n_j;
    logic [VALUE_W-1:0] r_ctr_a, n_ctr_a, r_ctr_b, n_ctr_b;
    logic               r_ov_seen, n_ov_seen;
    logic               r_ov_run, n_ov_run;
    logic               r_sub, n_sub;
    logic               r_out_valid;
    t_out               r_out, n_out;

    logic               in_xfer, out_free, ld;
    logic               wr_a, wr_b;
    logic [IDX_W-1:0]   rd_idx_a, rd_idx_b;
    logic [VALUE_W-1:0] rd_coef_a, rd_coef_b;
    logic               a_v, b_v, eq, take_a, take_b, done;
    logic [CNT_W-1:0]   nx_i, nx_j;
    logic [VALUE_W-1:0] alu_a, alu_b, alu_res;
    logic               alu_sub, alu_ov;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign ld          = out_free && ((r_state == S_CENT) || (r_state == S_MRG));
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Append writes
    assign wr_a = in_xfer && (i_in.req_type == REQ_TERM_A) && (r_cnt_a < CNT_MAX);
    assign wr_b = in_xfer && (i_in.req_type == REQ_TERM_B) && (r_cnt_b < CNT_MAX);

    saf_term_store #(.DEPTH(MAX_TERMS), .ADDR_W(ADDR_W), .IDX_W(IDX_W)) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (r_cnt_a[ADDR_W-1:0]),
        .i_wr_idx  (i_in.noise_index[IDX_W-1:0]),
        .i_wr_coef (i_in.value),
        .i_rd_addr (r_i[ADDR_W-1:0]),
        .o_rd_idx  (rd_idx_a),
        .o_rd_coef (rd_coef_a)
    );

    saf_term_store #(.DEPTH(MAX_TERMS), .ADDR_W(ADDR_W), .IDX_W(IDX_W)) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (r_cnt_b[ADDR_W-1:0]),
        .i_wr_idx  (i_in.noise_index[IDX_W-1:0]),
        .i_wr_coef (i_in.value),
        .i_rd_addr (r_j[ADDR_W-1:0]),
        .o_rd_idx  (rd_idx_b),
        .o_rd_coef (rd_coef_b)
    );

    // Merge decision on the heads read last cycle
    always_comb begin
        a_v    = r_i < r_cnt_a;
        b_v    = r_j < r_cnt_b;
        eq     = a_v && b_v && (rd_idx_a == rd_idx_b);
        take_a = !eq && (!b_v || (a_v && (rd_idx_a < rd_idx_b)));
        take_b = !eq && !take_a;
        nx_i   = r_i + CNT_W'(eq || take_a);
        nx_j   = r_j + CNT_W'(eq || take_b);
        done   = (nx_i >= r_cnt_a) && (nx_j >= r_cnt_b);
    end

    // Select operands for the shared saturating unit
    always_comb begin
        if (r_state == S_CENT) begin
            alu_a   = r_ctr_a;
            alu_b   = r_ctr_b;
            alu_sub = r_sub;
        end else if (eq) begin
            alu_a   = rd_coef_a;
            alu_b   = rd_coef_b;
            alu_sub = r_sub;
        end else if (take_a) begin
            alu_a   = rd_coef_a;
            alu_b   = '0;
            alu_sub = 1'b0;
        end else begin
            alu_a   = '0;
            alu_b   = rd_coef_b;
            alu_sub = r_sub;
        end
    end

    saf_sat_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res),
        .o_ov  (alu_ov)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_i       = r_i;
        n_j       = r_j;
        n_ctr_a   = r_ctr_a;
        n_ctr_b   = r_ctr_b;
        n_ov_seen = r_ov_seen;
        n_ov_run  = r_ov_run;
        n_sub     = r_sub;
        n_out     = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    priority case (i_in.req_type)
                        REQ_TERM_A: begin
                            if (wr_a) n_cnt_a = r_cnt_a + 1'b1;
                            else      n_ov_seen = 1'b1;
                        end
                        REQ_TERM_B: begin
                            if (wr_b) n_cnt_b = r_cnt_b + 1'b1;
                            else      n_ov_seen = 1'b1;
                        end
                        REQ_CENTER_A: n_ctr_a = i_in.value;
                        REQ_CENTER_B: n_ctr_b = i_in.value;
                        REQ_COMBINE: begin
                            n_sub   = i_in.subtract;
                            n_i     = '0;
                            n_j     = '0;
                            n_state = S_CENT;
                        end
                        default: ;
                    endcase
                end
            end
            S_CENT: begin
                if (ld) begin
                    n_ov_run              = r_ov_seen || alu_ov;
                    n_out.is_term         = 1'b0;
                    n_out.noise_index_res = '0;
                    n_out.value_res       = alu_res;
                    n_out.overflow        = r_ov_seen || alu_ov;
                    n_out.last            = (r_cnt_a == '0) && (r_cnt_b == '0);
                    n_state               = n_out.last ? S_IDLE : S_MRG;
                end
            end
            S_RD: begin
                n_state = S_MRG;
            end
            S_MRG: begin
                if (ld) begin
                    n_ov_run              = r_ov_run || alu_ov;
                    n_out.is_term         = 1'b1;
                    n_out.noise_index_res = NIDX_W'(eq || take_a ? rd_idx_a : rd_idx_b);
                    n_out.value_res       = alu_res;
                    n_out.overflow        = r_ov_run || alu_ov;
                    n_out.last            = done;
                    n_i                   = nx_i;
                    n_j                   = nx_j;
                    n_state               = done ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Drop both forms once the final item is loaded
        if (ld && n_out.last) begin
            n_cnt_a   = '0;
            n_cnt_b   = '0;
            n_i       = '0;
            n_j       = '0;
            n_ctr_a   = '0;
            n_ctr_b   = '0;
            n_ov_seen = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ctr_a     <= '0;
            r_ctr_b     <= '0;
            r_ov_seen   <= 1'b0;
            r_ov_run    <= 1'b0;
            r_sub       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_ctr_a     <= n_ctr_a;
            r_ctr_b     <= n_ctr_b;
            r_ov_seen   <= n_ov_seen;
            r_ov_run    <= n_ov_run;
            r_sub       <= n_sub;
            r_out_valid <= ld || (r_out_valid && !i_out_ready);
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Pointers stay within the loaded counts
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= r_cnt_a) && (r_j <= r_cnt_b))
        else $error("merge pointer beyond term count");

    // A merge step always has a term left on some side
    a_mrg_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG) |-> ((r_i < r_cnt_a) || (r_j < r_cnt_b)))
        else $error("merge step with both forms exhausted");

    // Loading the final item returns the sequencer to idle with empty forms
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && n_out.last) |=> ((r_state == S_IDLE) && (r_cnt_a == '0) && (r_cnt_b == '0)))
        else $error("combine did not finish cleanly");

    // Counts never exceed capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_MAX) && (r_cnt_b <= CNT_MAX))
        else $error("term count beyond capacity");

endmodule

`default_nettype wire
